// File: rtl/core/ccs_pkg.sv
// Shared types and constants for the C comment stripper.
// Used by the scanner, the result queue and the top level; depends on nothing.
package ccs_pkg;

    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_STAR  = 8'h2A;
    localparam logic [7:0] CH_NL    = 8'h0A;

    localparam logic [2:0] M_NORMAL = 3'd0;
    localparam logic [2:0] M_SLASH  = 3'd1;
    localparam logic [2:0] M_LINE   = 3'd2;
    localparam logic [2:0] M_BFIRST = 3'd3;
    localparam logic [2:0] M_BLOCK  = 3'd4;
    localparam logic [2:0] M_BSLASH = 3'd5;
    localparam logic [2:0] M_BSTAR  = 3'd6;

    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       nest_error;
        logic       done_res;
        logic       last;
    } ccs_res_t;

    function automatic ccs_res_t ccs_mk(input logic [7:0] b, input logic v,
                                        input logic d, input logic ne);
        ccs_res_t r;
        r.out_byte   = b;
        r.byte_valid = v;
        r.nest_error = ne;
        r.done_res   = d;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

// File: rtl/core/ccs_scan.sv
// Comment scanner: mode registers and the per-byte decode that yields up to two words.
// Depends on ccs_pkg.
module ccs_scan import ccs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       take,
    input  logic       req_type,
    input  logic [7:0] in_byte,
    output ccs_res_t   res0,
    output ccs_res_t   res1,
    output logic [1:0] res_cnt
);

    logic [2:0] mode_reg, mode_next;
    logic       pad_reg, pad_next;
    logic       nest_reg, nest_next;
    ccs_res_t   r0, r1;
    logic [1:0] cnt;

    always_comb begin
        mode_next = mode_reg;
        pad_next  = pad_reg;
        nest_next = nest_reg;
        r0  = ccs_mk(8'h00, 1'b0, 1'b0, nest_reg);
        r1  = ccs_mk(8'h00, 1'b0, 1'b0, nest_reg);
        cnt = 2'd0;
        if (req_type) begin
            mode_next = M_NORMAL;
            pad_next  = 1'b0;
            if (mode_reg == M_SLASH) begin
                r0  = ccs_mk(CH_SLASH, 1'b1, 1'b0, nest_reg);
                r1  = ccs_mk(8'h00, 1'b0, 1'b1, nest_reg);
                cnt = 2'd2;
            end else if (mode_reg >= M_BFIRST && mode_reg <= M_BSTAR && pad_reg) begin
                r0  = ccs_mk(CH_NL, 1'b1, 1'b0, nest_reg);
                r1  = ccs_mk(8'h00, 1'b0, 1'b1, nest_reg);
                cnt = 2'd2;
            end else begin
                r0  = ccs_mk(8'h00, 1'b0, 1'b1, nest_reg);
                cnt = 2'd1;
            end
        end else begin
            case (mode_reg)
                M_SLASH: begin
                    if (in_byte == CH_STAR) begin
                        mode_next = M_BFIRST;
                        pad_next  = 1'b0;
                    end else if (in_byte == CH_SLASH) begin
                        mode_next = M_LINE;
                    end else begin
                        r0  = ccs_mk(CH_SLASH, 1'b1, 1'b0, nest_reg);
                        r1  = ccs_mk(in_byte, 1'b1, 1'b0, nest_reg);
                        cnt = 2'd2;
                        mode_next = M_NORMAL;
                    end
                end
                M_LINE: begin
                    if (in_byte == CH_NL) begin
                        r0  = ccs_mk(in_byte, 1'b1, 1'b0, nest_reg);
                        cnt = 2'd1;
                        mode_next = M_NORMAL;
                    end
                end
                M_BFIRST, M_BLOCK, M_BSTAR: begin
                    if (in_byte == CH_SLASH && mode_reg != M_BLOCK) begin
                        mode_next = M_NORMAL;
                        pad_next  = 1'b0;
                        if (pad_reg) begin
                            r0  = ccs_mk(CH_NL, 1'b1, 1'b0, nest_reg);
                            cnt = 2'd1;
                        end
                    end else if (in_byte == CH_NL) begin
                        pad_next  = 1'b1;
                        mode_next = M_BLOCK;
                    end else if (in_byte == CH_SLASH) begin
                        mode_next = M_BSLASH;
                    end else if (in_byte == CH_STAR) begin
                        mode_next = M_BSTAR;
                    end else begin
                        mode_next = M_BLOCK;
                    end
                end
                M_BSLASH: begin
                    if (in_byte == CH_STAR) begin
                        nest_next = 1'b1;
                        mode_next = M_BSTAR;
                    end else begin
                        if (in_byte == CH_NL) begin
                            pad_next = 1'b1;
                        end
                        mode_next = M_BLOCK;
                    end
                end
                default: begin
                    if (in_byte == CH_SLASH) begin
                        mode_next = M_SLASH;
                    end else begin
                        r0  = ccs_mk(in_byte, 1'b1, 1'b0, nest_reg);
                        cnt = 2'd1;
                        mode_next = M_NORMAL;
                    end
                end
            endcase
        end
        if (cnt == 2'd1) begin
            r0.last = 1'b1;
        end
        if (cnt == 2'd2) begin
            r1.last = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= M_NORMAL;
            pad_reg  <= 1'b0;
            nest_reg <= 1'b0;
        end else if (take) begin
            mode_reg <= mode_next;
            pad_reg  <= pad_next;
            nest_reg <= nest_next;
        end
    end

    assign res0    = r0;
    assign res1    = r1;
    assign res_cnt = cnt;

`ifndef SYNTHESIS
    a_nest_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        nest_reg |=> nest_reg)
        else $error("nest error flag cleared without reset");
    a_pad_in_block: assert property (@(posedge aclk) disable iff (!aresetn)
        pad_reg |-> (mode_reg >= M_BFIRST && mode_reg <= M_BSTAR))
        else $error("pending newline outside a block comment");
`endif

endmodule

// File: rtl/core/ccs_queue.sv
// Result queue: takes zero, one or two words per cycle and hands out one word per cycle while pop_ready is high.
// Depends on ccs_pkg.
module ccs_queue import ccs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [1:0] push_cnt,
    input  ccs_res_t   push0,
    input  ccs_res_t   push1,
    output logic       room2,
    output logic       pop_valid,
    input  logic       pop_ready,
    output ccs_res_t   pop_data
);

    ccs_res_t         mem_reg [QDEPTH];
    logic [QAW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [QAW:0]     count_reg;
    logic             pop;
    logic [QAW-1:0]   wr_ptr1;

    assign pop       = pop_valid && pop_ready;
    assign pop_valid = count_reg != '0;
    assign pop_data  = mem_reg[rd_ptr_reg];
    assign room2     = count_reg <= (QAW+1)'(QDEPTH - 2);
    assign wr_ptr1   = wr_ptr_reg + QAW'(1);

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2) begin
            mem_reg[wr_ptr1] <= push1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + QAW'(push_cnt);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QAW'(1);
            end
            count_reg <= count_reg + (QAW+1)'(push_cnt) - (QAW+1)'(pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_cnt != 2'd0 |-> count_reg + (QAW+1)'(push_cnt) <= (QAW+1)'(QDEPTH))
        else $error("result queue overflow");
`endif

endmodule

// File: rtl/core/c_comment_stripper.sv
// Top level of the C comment stripper: input handshake, scanner and result queue.
// Depends on ccs_pkg, ccs_scan and ccs_queue.
//
// Text enters one word per cycle and leaves with C block and line comments removed;
// an end-of-stream word flushes a pending slash or padding newline and yields a done
// word. Each input word is decoded in the cycle it is accepted and its zero, one or
// two output words land in a four-entry queue that drives the m_ port from registers.
// The input takes one word every cycle while the queue has room for two more, so with
// m_ready held high the sustained rate is one input word per cycle; words that expand to
// two output words are limited by the single output word per cycle.
module c_comment_stripper import ccs_pkg::*; (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       s_req_type,
    input  logic [7:0] s_in_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_byte_valid,
    output logic       m_nest_error,
    output logic       m_done_res,
    output logic       m_last
);

    logic       take;
    logic       room2;
    ccs_res_t   res0, res1, head;
    logic [1:0] res_cnt;
    logic [1:0] push_cnt;

    assign s_ready  = room2;
    assign take     = s_valid && s_ready;
    assign push_cnt = take ? res_cnt : 2'd0;

    ccs_scan u_scan (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .take     (take),
        .req_type (s_req_type),
        .in_byte  (s_in_byte),
        .res0     (res0),
        .res1     (res1),
        .res_cnt  (res_cnt)
    );

    ccs_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_cnt  (push_cnt),
        .push0     (res0),
        .push1     (res1),
        .room2     (room2),
        .pop_valid (m_valid),
        .pop_ready (m_ready),
        .pop_data  (head)
    );

    assign m_out_byte   = head.out_byte;
    assign m_byte_valid = head.byte_valid;
    assign m_nest_error = head.nest_error;
    assign m_done_res   = head.done_res;
    assign m_last       = head.last;

`ifndef SYNTHESIS
    a_empty_is_done: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_byte_valid) |-> (m_done_res && m_last))
        else $error("word without a character is not the final done word");
    a_done_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_done_res) |-> (!m_byte_valid && m_out_byte == 8'h00))
        else $error("done word carries a character");
`endif

endmodule

// File: tb/c_comment_stripper_tb.sv
`timescale 1ns / 100ps
// Testbench for c_comment_stripper: a directed table, then random C-like text, checked word
// by word against the table or a behavioral scanner model. Depends on ccs_pkg and the RTL.
module c_comment_stripper_tb;
    import ccs_pkg::*;

    localparam int CLK_HALF     = 4;
    localparam int TOTAL_WORDS  = 1550;
    localparam int QUIET_TAIL   = 200;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 20;
    localparam int TYPED_NONE   = -1;
    localparam logic REQ_DATA   = 1'b0;
    localparam logic REQ_EOS    = 1'b1;

    typedef struct {
        logic       req;
        logic [7:0] b;
        int         n;
        ccs_res_t   w0;
        ccs_res_t   w1;
    } row_t;

    logic       aclk       = 1'b0;
    logic       aresetn    = 1'b0;
    logic       s_valid    = 1'b0;
    logic       s_req_type = 1'b0;
    logic [7:0] s_in_byte  = 8'h00;
    logic       m_ready    = 1'b0;
    logic       s_ready;
    logic       m_valid;
    logic [7:0] m_out_byte;
    logic       m_byte_valid;
    logic       m_nest_error;
    logic       m_done_res;
    logic       m_last;

    logic [2:0] scan_st     = M_NORMAL;
    logic       pad_pending = 1'b0;
    logic       nest_seen   = 1'b0;
    ccs_res_t   step_words[$];
    ccs_res_t   stripped_q[$];
    row_t       dir_rows[$];
    ccs_res_t   head_word;
    logic       idle_ok     = 1'b1;
    logic       rdy_next;
    int         stall_left  = 0;
    int         words_sent  = 0;
    int         mismatches  = 0;
    int         cycles      = 0;

    c_comment_stripper dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_in_byte    (s_in_byte),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_out_byte   (m_out_byte),
        .m_byte_valid (m_byte_valid),
        .m_nest_error (m_nest_error),
        .m_done_res   (m_done_res),
        .m_last       (m_last)
    );

    initial begin
        forever #CLK_HALF aclk = ~aclk;
    end

    function automatic ccs_res_t make_word(logic [7:0] b, logic v, logic ne, logic d, logic l);
        ccs_res_t w;
        w.out_byte   = b;
        w.byte_valid = v;
        w.nest_error = ne;
        w.done_res   = d;
        w.last       = l;
        return w;
    endfunction

    function automatic void emit_word(logic [7:0] b, logic v, logic d);
        step_words.push_back(make_word(b, v, nest_seen, d, 1'b0));
    endfunction

    function automatic void end_block();
        scan_st = M_NORMAL;
        if (pad_pending) begin
            pad_pending = 1'b0;
            emit_word(CH_NL, 1'b1, 1'b0);
        end
    endfunction

    function automatic void block_text(logic [7:0] c);
        if (c == CH_NL) begin
            pad_pending = 1'b1;
            scan_st = M_BLOCK;
        end else if (c == CH_SLASH) begin
            scan_st = M_BSLASH;
        end else if (c == CH_STAR) begin
            scan_st = M_BSTAR;
        end else begin
            scan_st = M_BLOCK;
        end
    endfunction

    function automatic void strip_predict(logic req, logic [7:0] c);
        step_words.delete();
        if (req == REQ_EOS) begin
            if (scan_st == M_SLASH) begin
                emit_word(CH_SLASH, 1'b1, 1'b0);
            end else if (scan_st >= M_BFIRST && scan_st <= M_BSTAR && pad_pending) begin
                emit_word(CH_NL, 1'b1, 1'b0);
            end
            scan_st = M_NORMAL;
            pad_pending = 1'b0;
            emit_word(8'h00, 1'b0, 1'b1);
        end else begin
            case (scan_st)
                M_SLASH: begin
                    if (c == CH_STAR) begin
                        scan_st = M_BFIRST;
                        pad_pending = 1'b0;
                    end else if (c == CH_SLASH) begin
                        scan_st = M_LINE;
                    end else begin
                        emit_word(CH_SLASH, 1'b1, 1'b0);
                        emit_word(c, 1'b1, 1'b0);
                        scan_st = M_NORMAL;
                    end
                end
                M_LINE: begin
                    if (c == CH_NL) begin
                        emit_word(c, 1'b1, 1'b0);
                        scan_st = M_NORMAL;
                    end
                end
                M_BFIRST: begin
                    if (c == CH_SLASH) end_block();
                    else block_text(c);
                end
                M_BLOCK: block_text(c);
                M_BSLASH: begin
                    if (c == CH_STAR) begin
                        nest_seen = 1'b1;
                        scan_st = M_BSTAR;
                    end else begin
                        if (c == CH_NL) pad_pending = 1'b1;
                        scan_st = M_BLOCK;
                    end
                end
                M_BSTAR: begin
                    if (c == CH_STAR) begin
                        scan_st = M_BSTAR;
                    end else if (c == CH_SLASH) begin
                        end_block();
                    end else begin
                        if (c == CH_NL) pad_pending = 1'b1;
                        scan_st = M_BLOCK;
                    end
                end
                default: begin
                    if (c == CH_SLASH) begin
                        scan_st = M_SLASH;
                    end else begin
                        emit_word(c, 1'b1, 1'b0);
                        scan_st = M_NORMAL;
                    end
                end
            endcase
        end
        if (step_words.size() > 0) step_words[step_words.size() - 1].last = 1'b1;
    endfunction

    function automatic void add_row(logic req, logic [7:0] b, int n, ccs_res_t w0, ccs_res_t w1);
        row_t r;
        r.req = req;
        r.b   = b;
        r.n   = n;
        r.w0  = w0;
        r.w1  = w1;
        dir_rows.push_back(r);
    endfunction

    function automatic logic [7:0] pick_text();
        case ($urandom_range(0, 7))
            0: return CH_SLASH;
            1: return CH_STAR;
            2: return CH_NL;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            mismatches++;
            $display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic send_word(logic req, logic [7:0] b, int typed_n, ccs_res_t w0, ccs_res_t w1);
        s_valid    <= 1'b1;
        s_req_type <= req;
        s_in_byte  <= b;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        words_sent++;
        strip_predict(req, b);
        if (typed_n == TYPED_NONE) begin
            foreach (step_words[i]) stripped_q.push_back(step_words[i]);
        end else begin
            if (typed_n > 0) stripped_q.push_back(w0);
            if (typed_n > 1) stripped_q.push_back(w1);
        end
        if (idle_ok && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge aclk);
        end
    endtask

    task automatic send_text(logic [7:0] b);
        send_word(REQ_DATA, b, TYPED_NONE, '0, '0);
    endtask

    task automatic send_snippet();
        case ($urandom_range(0, 19))
            0, 1, 2, 3, 4: begin
                repeat ($urandom_range(1, 8)) send_text(8'($urandom_range(0, 255)));
            end
            5, 6, 7: begin
                send_text(CH_SLASH);
                send_text(CH_SLASH);
                repeat ($urandom_range(0, 6)) send_text(pick_text());
                send_text(CH_NL);
            end
            8, 9, 10, 11: begin
                send_text(CH_SLASH);
                send_text(CH_STAR);
                repeat ($urandom_range(0, 8)) send_text(pick_text());
                repeat ($urandom_range(1, 3)) send_text(CH_STAR);
                send_text(CH_SLASH);
            end
            12, 13: begin
                send_text(CH_SLASH);
                send_text(CH_STAR);
                send_text(CH_SLASH);
            end
            14, 15: begin
                send_text(CH_SLASH);
                send_text(CH_STAR);
                repeat ($urandom_range(0, 4)) send_text(pick_text());
                send_text(CH_SLASH);
                send_text(CH_STAR);
                repeat ($urandom_range(0, 4)) send_text(pick_text());
                send_text(CH_STAR);
                send_text(CH_SLASH);
            end
            16: send_word(REQ_EOS, 8'($urandom_range(0, 255)), TYPED_NONE, '0, '0);
            default: begin
                send_text(CH_SLASH);
                send_text(pick_text());
            end
        endcase
    endtask

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (stripped_q.size() == 0) begin
                    mismatches++;
                    $display("%0t: expected no word, actual byte %0h valid %0b done %0b last %0b",
                             $time, m_out_byte, m_byte_valid, m_done_res, m_last);
                end else begin
                    head_word = stripped_q.pop_front();
                    check_field("out_byte", 32'(head_word.out_byte), 32'(m_out_byte));
                    check_field("byte_valid", 32'(head_word.byte_valid), 32'(m_byte_valid));
                    check_field("nest_error", 32'(head_word.nest_error), 32'(m_nest_error));
                    check_field("done_res", 32'(head_word.done_res), 32'(m_done_res));
                    check_field("last", 32'(head_word.last), 32'(m_last));
                end
            end
            rdy_next = 1'b1;
            if (stall_left > 0 && idle_ok) begin
                stall_left--;
                rdy_next = 1'b0;
            end else if (idle_ok && $urandom_range(0, 5) == 0) begin
                stall_left = $urandom_range(0, 15);
                rdy_next = 1'b0;
            end
            m_ready <= rdy_next;
        end
    end

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        add_row(REQ_DATA, 8'h61, 1, make_word(8'h61, 1'b1, 1'b0, 1'b0, 1'b1), '0);
        add_row(REQ_DATA, 8'h00, 1, make_word(8'h00, 1'b1, 1'b0, 1'b0, 1'b1), '0);
        add_row(REQ_DATA, 8'hFF, 1, make_word(8'hFF, 1'b1, 1'b0, 1'b0, 1'b1), '0);
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_DATA, 8'h78, 2, make_word(CH_SLASH, 1'b1, 1'b0, 1'b0, 1'b0),
                make_word(8'h78, 1'b1, 1'b0, 1'b0, 1'b1));
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_DATA, 8'h63, 0, '0, '0);
        add_row(REQ_DATA, CH_NL, 1, make_word(CH_NL, 1'b1, 1'b0, 1'b0, 1'b1), '0);
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_DATA, CH_STAR, 0, '0, '0);
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_DATA, CH_STAR, 0, '0, '0);
        add_row(REQ_DATA, CH_NL, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_STAR, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_SLASH, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_SLASH, 0, '0, '0);
        add_row(REQ_EOS, 8'h00, 2, make_word(CH_SLASH, 1'b1, 1'b0, 1'b0, 1'b0),
                make_word(8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
        add_row(REQ_DATA, CH_SLASH, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_STAR, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_NL, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_SLASH, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, CH_STAR, TYPED_NONE, '0, '0);
        add_row(REQ_EOS, 8'hFF, TYPED_NONE, '0, '0);
        add_row(REQ_DATA, 8'h71, TYPED_NONE, '0, '0);

        foreach (dir_rows[i]) begin
            send_word(dir_rows[i].req, dir_rows[i].b, dir_rows[i].n, dir_rows[i].w0,
                      dir_rows[i].w1);
        end

        while (words_sent < TOTAL_WORDS) begin
            if (words_sent >= TOTAL_WORDS - QUIET_TAIL) begin
                idle_ok = 1'b0;
            end else if ($urandom_range(0, 31) == 0) begin
                idle_ok = !idle_ok;
            end
            if ($urandom_range(0, 3) == 0) begin
                if ($urandom_range(0, 49) == 0) begin
                    send_word(REQ_EOS, 8'($urandom_range(0, 255)), TYPED_NONE, '0, '0);
                end else begin
                    send_text($urandom_range(0, 1) ? pick_text() : 8'($urandom_range(0, 255)));
                end
            end else begin
                send_snippet();
            end
        end
        s_valid <= 1'b0;

        while (stripped_q.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
